/* sv/tcdc_pkg.sv */
package tcdc_pkg;

  localparam int VOLT_BITS    = 16;
  localparam int POWER_BITS   = 32;
  localparam int MODE_BITS    = 2;
  localparam int SSIZE_BITS   = 13;
  localparam int NSTEPS_BITS  = 6;
  localparam int STEP_BITS    = 7;
  localparam int CHANGE_BITS  = 8;
  localparam int RATIO_BITS   = 17;

  localparam int ADDR_BITS    = 5;
  localparam int DATA_BITS    = 32;
  localparam int IDX_BITS     = 3;

  // |2(v - vref)| - band, and the divisor 2 * step_size
  localparam int MAG_BITS     = VOLT_BITS + 1;
  localparam int DIVISOR_BITS = SSIZE_BITS + 1;

  localparam int QSAT         = 128;
  localparam int Q_BITS       = $clog2(QSAT) + 1;
  localparam int SUM_BITS     = 10;
  localparam int PROD_BITS    = STEP_BITS + SSIZE_BITS + 1;
  localparam int RSUM_BITS    = PROD_BITS + 1;

  localparam int RATIO_ONE      = 16384;
  localparam int RATIO_MAX      = 131071;
  localparam int POWER_DEADZONE = 100;

  localparam int DEF_MAX_STEPS  = 32;
  localparam int DEF_VOLT_WIDTH = 16;

  localparam logic [MODE_BITS-1:0] MODE_FORWARD = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_POWER   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_LOCKED  = 2'd2;

  localparam logic [MODE_BITS-1:0] SUB_INVERT    = 2'd0;
  localparam logic [MODE_BITS-1:0] SUB_BYPASS    = 2'd1;
  localparam logic [MODE_BITS-1:0] SUB_NO_INVERT = 2'd2;

  localparam logic [VOLT_BITS-1:0]   RST_VREF   = 16'd16384;
  localparam logic [VOLT_BITS-1:0]   RST_BAND   = 16'd328;
  localparam logic [SSIZE_BITS-1:0]  RST_SSIZE  = 13'd102;
  localparam logic [NSTEPS_BITS-1:0] RST_NSTEPS = 6'd16;

  typedef enum logic [IDX_BITS-1:0] {
    REG_CONTROL_MODE     = 3'd0,
    REG_REVERSE_SUB_MODE = 3'd1,
    REG_VREF_FORWARD     = 3'd2,
    REG_VREF_REVERSE     = 3'd3,
    REG_BAND_FORWARD     = 3'd4,
    REG_BAND_REVERSE     = 3'd5,
    REG_STEP_SIZE        = 3'd6,
    REG_NUM_STEPS        = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]   control_mode;
    logic [MODE_BITS-1:0]   reverse_sub_mode;
    logic [VOLT_BITS-1:0]   vref_forward;
    logic [VOLT_BITS-1:0]   vref_reverse;
    logic [VOLT_BITS-1:0]   band_forward;
    logic [VOLT_BITS-1:0]   band_reverse;
    logic [SSIZE_BITS-1:0]  step_size;
    logic [NSTEPS_BITS-1:0] num_steps;
  } cfg_t;

  typedef struct packed {
    logic                    start;
    logic [MAG_BITS-1:0]     dividend;
    logic [DIVISOR_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [MAG_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

/* sv/tcdc_meas_if.sv */
interface tcdc_meas_if;
  import tcdc_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [VOLT_BITS-1:0]         volt_fwd_bus;
  logic [VOLT_BITS-1:0]         volt_rev_bus;
  logic signed [POWER_BITS-1:0] active_power_w;
  logic                         fwd_bus_ok;
  logic                         rev_bus_ok;
  logic                         terminals_ok;

  modport source (
    output valid, volt_fwd_bus, volt_rev_bus, active_power_w,
    output fwd_bus_ok, rev_bus_ok, terminals_ok,
    input  ready
  );

  modport sink (
    input  valid, volt_fwd_bus, volt_rev_bus, active_power_w,
    input  fwd_bus_ok, rev_bus_ok, terminals_ok,
    output ready
  );

endinterface

/* sv/tcdc_result_if.sv */
interface tcdc_result_if;
  import tcdc_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          success;
  logic                          tap_changed;
  logic signed [STEP_BITS-1:0]   step_now;
  logic signed [CHANGE_BITS-1:0] step_change;
  logic [RATIO_BITS-1:0]         tap_ratio;
  logic                          flow_reverse;

  modport source (
    output valid, success, tap_changed, step_now, step_change, tap_ratio, flow_reverse,
    input  ready
  );

  modport sink (
    input  valid, success, tap_changed, step_now, step_change, tap_ratio, flow_reverse,
    output ready
  );

endinterface

/* sv/tcdc_regs.sv */
module tcdc_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcdc_pkg::ADDR_BITS-1:0] paddr,
  input  logic [tcdc_pkg::DATA_BITS-1:0] pwdata,
  output logic [tcdc_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready,
  output tcdc_pkg::cfg_t                 cfg
);
  import tcdc_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.control_mode     <= MODE_FORWARD;
      cfg.reverse_sub_mode <= SUB_INVERT;
      cfg.vref_forward     <= RST_VREF;
      cfg.vref_reverse     <= RST_VREF;
      cfg.band_forward     <= RST_BAND;
      cfg.band_reverse     <= RST_BAND;
      cfg.step_size        <= RST_SSIZE;
      cfg.num_steps        <= RST_NSTEPS;
    end else if (wr_en) begin
      unique case (idx)
        REG_CONTROL_MODE:     cfg.control_mode     <= pwdata[MODE_BITS-1:0];
        REG_REVERSE_SUB_MODE: cfg.reverse_sub_mode <= pwdata[MODE_BITS-1:0];
        REG_VREF_FORWARD:     cfg.vref_forward     <= pwdata[VOLT_BITS-1:0];
        REG_VREF_REVERSE:     cfg.vref_reverse     <= pwdata[VOLT_BITS-1:0];
        REG_BAND_FORWARD:     cfg.band_forward     <= pwdata[VOLT_BITS-1:0];
        REG_BAND_REVERSE:     cfg.band_reverse     <= pwdata[VOLT_BITS-1:0];
        REG_STEP_SIZE:        cfg.step_size        <= pwdata[SSIZE_BITS-1:0];
        REG_NUM_STEPS:        cfg.num_steps        <= pwdata[NSTEPS_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_CONTROL_MODE:     prdata[MODE_BITS-1:0]   = cfg.control_mode;
      REG_REVERSE_SUB_MODE: prdata[MODE_BITS-1:0]   = cfg.reverse_sub_mode;
      REG_VREF_FORWARD:     prdata[VOLT_BITS-1:0]   = cfg.vref_forward;
      REG_VREF_REVERSE:     prdata[VOLT_BITS-1:0]   = cfg.vref_reverse;
      REG_BAND_FORWARD:     prdata[VOLT_BITS-1:0]   = cfg.band_forward;
      REG_BAND_REVERSE:     prdata[VOLT_BITS-1:0]   = cfg.band_reverse;
      REG_STEP_SIZE:        prdata[SSIZE_BITS-1:0]  = cfg.step_size;
      REG_NUM_STEPS:        prdata[NSTEPS_BITS-1:0] = cfg.num_steps;
    endcase
  end

endmodule

/* sv/tcdc_div.sv */
module tcdc_div (
  input  logic               clk,
  input  logic               rst,
  input  tcdc_pkg::div_req_t req,
  output tcdc_pkg::div_rsp_t rsp
);
  import tcdc_pkg::*;

  localparam int STEPS    = MAG_BITS;
  localparam int CNT_BITS = $clog2(STEPS);

  logic                    busy;
  logic                    done;
  logic [CNT_BITS-1:0]     cnt;
  logic [DIVISOR_BITS-1:0] rem;
  logic [DIVISOR_BITS-1:0] dsr;
  logic [MAG_BITS-1:0]     dvd;
  logic [MAG_BITS-1:0]     quo;
  logic [DIVISOR_BITS:0]   trial;
  logic [DIVISOR_BITS:0]   diff;
  logic                    fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, dvd[MAG_BITS-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= req.dividend;
        dsr  <= req.divisor;
      end else if (busy) begin
        rem <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        quo <= {quo[MAG_BITS-2:0], fits};
        dvd <= {dvd[MAG_BITS-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* sv/tap_changer_deadband_control.sv */
// Tap changer dead band control for a step voltage regulator.
// Measurement words arrive on the meas channel (valid/ready); each one is a
// control evaluation and yields exactly one word on the result channel.
// Control registers sit on an APB-style port, 4 bytes apart, pready tied high;
// write them only while the block is idle.
// When a step move needs a division (nonzero magnitude and step size), the
// quotient comes from the bit-serial divider, one quotient bit per cycle.
// One word is in work at a time: meas ready is high only while the
// sequencer idles, so a new word is taken only once the last one has
// reached the output register.
// The result sits in an output register; the next word is accepted while it
// waits. If the receiver stalls, the finished evaluation holds in its final
// step until the output register frees, and no new word is taken meanwhile.
// Reset (rst, synchronous) restores the register defaults, sets the step
// position and its previous value to zero, clears result valid and returns to idle.
module tap_changer_deadband_control #(
  parameter int MAX_STEPS  = tcdc_pkg::DEF_MAX_STEPS,
  parameter int VOLT_WIDTH = tcdc_pkg::DEF_VOLT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcdc_pkg::ADDR_BITS-1:0] paddr,
  input  logic [tcdc_pkg::DATA_BITS-1:0] pwdata,
  output logic [tcdc_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready,
  tcdc_meas_if.sink                      meas,
  tcdc_result_if.source                  result
);
  import tcdc_pkg::*;

  localparam int V_EFF = (VOLT_WIDTH < VOLT_BITS) ? VOLT_WIDTH : VOLT_BITS;
  localparam logic [VOLT_BITS-1:0] VMASK = VOLT_BITS'((64'd1 << V_EFF) - 64'd1);
  localparam logic [NSTEPS_BITS-1:0] LIM_MAX = NSTEPS_BITS'(MAX_STEPS);
  localparam logic signed [SUM_BITS-1:0] POS_LIM = SUM_BITS'(MAX_STEPS);
  localparam logic signed [POWER_BITS-1:0] POWER_REV_LIMIT = POWER_BITS'(-POWER_DEADZONE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_APPLY,
    S_MUL,
    S_DONE
  } state_t;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;
  state_t   state;

  logic [VOLT_BITS-1:0]         vfwd_r;
  logic [VOLT_BITS-1:0]         vrev_r;
  logic signed [POWER_BITS-1:0] power_r;
  logic                         fwd_ok_r;
  logic                         rev_ok_r;
  logic                         term_ok_r;

  logic signed [STEP_BITS-1:0]  step_pos;
  logic signed [STEP_BITS-1:0]  step_prev;
  logic                         ok_r;
  logic                         rev_r;
  logic                         zero_r;
  logic                         move_r;
  logic                         neg_r;
  logic [MAG_BITS-1:0]          mag_r;
  logic signed [PROD_BITS-1:0]  prod_r;

  logic                         locked;
  logic                         pow_mode;
  logic                         rev;
  logic                         term_fail;
  logic                         bypass;
  logic                         bus_ok;
  logic                         vf_ge;
  logic                         outside;
  logic                         invert;
  logic                         move_go;
  logic                         div_go;
  logic [VOLT_BITS-1:0]         vf;
  logic [VOLT_BITS-1:0]         vref;
  logic [VOLT_BITS-1:0]         band;
  logic [VOLT_BITS-1:0]         adiff;
  logic [MAG_BITS-1:0]          ad2;
  logic [MAG_BITS-1:0]          mag;

  logic [Q_BITS-1:0]            q_mag;
  logic signed [SUM_BITS-1:0]   pos_ext;
  logic signed [SUM_BITS-1:0]   move;
  logic signed [SUM_BITS-1:0]   sum;
  logic signed [SUM_BITS-1:0]   lim;
  logic signed [SUM_BITS-1:0]   pos_clamp;
  logic [NSTEPS_BITS-1:0]       lim_u;

  logic signed [RSUM_BITS-1:0]  ratio_sum;
  logic [RATIO_BITS-1:0]        ratio;
  logic                         out_free;

  tcdc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcdc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // evaluation of the captured word
  always_comb begin
    locked    = cfg.control_mode >= MODE_LOCKED;
    pow_mode  = cfg.control_mode == MODE_POWER;
    rev       = pow_mode && (power_r <= POWER_REV_LIMIT);
    term_fail = pow_mode && !term_ok_r;
    bypass    = rev && (cfg.reverse_sub_mode == SUB_BYPASS);
    bus_ok    = rev ? rev_ok_r : fwd_ok_r;
    vf        = (rev ? vrev_r : vfwd_r) & VMASK;
    vref      = (rev ? cfg.vref_reverse : cfg.vref_forward) & VMASK;
    band      = (rev ? cfg.band_reverse : cfg.band_forward) & VMASK;
    vf_ge     = vf >= vref;
    adiff     = vf_ge ? (vf - vref) : (vref - vf);
    ad2       = {adiff, 1'b0};
    outside   = ad2 >= {1'b0, band};
    mag       = ad2 - {1'b0, band};
    invert    = rev && (cfg.reverse_sub_mode != SUB_NO_INVERT);
    move_go   = !locked && !term_fail && !bypass && bus_ok && outside;
    div_go    = move_go && (mag != '0) && (cfg.step_size != '0);
  end

  assign div_req.start    = (state == S_EVAL) && div_go;
  assign div_req.dividend = mag;
  assign div_req.divisor  = {cfg.step_size, 1'b0};

  // truncated quotient plus one, saturated at QSAT, then clamp
  always_comb begin
    if (mag_r == '0) begin
      q_mag = '0;
    end else if (cfg.step_size == '0) begin
      q_mag = Q_BITS'(QSAT);
    end else if (div_rsp.quotient >= MAG_BITS'(QSAT - 1)) begin
      q_mag = Q_BITS'(QSAT);
    end else begin
      q_mag = div_rsp.quotient[Q_BITS-1:0] + Q_BITS'(1);
    end
    pos_ext = SUM_BITS'(step_pos);
    move    = neg_r ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
    sum     = pos_ext + move;
    lim_u   = (cfg.num_steps < LIM_MAX) ? cfg.num_steps : LIM_MAX;
    lim     = $signed({{(SUM_BITS-NSTEPS_BITS){1'b0}}, lim_u});
    if (sum > lim) begin
      pos_clamp = lim;
    end else if (sum < -lim) begin
      pos_clamp = -lim;
    end else begin
      pos_clamp = sum;
    end
  end

  always_comb begin
    ratio_sum = RSUM_BITS'(prod_r) + RSUM_BITS'(RATIO_ONE);
    if (ratio_sum < 0) begin
      ratio = '0;
    end else if (ratio_sum > RSUM_BITS'(RATIO_MAX)) begin
      ratio = RATIO_BITS'(RATIO_MAX);
    end else begin
      ratio = ratio_sum[RATIO_BITS-1:0];
    end
    out_free = !result.valid || result.ready;
  end

  assign meas.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step_pos     <= '0;
      step_prev    <= '0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && (state != S_DONE)) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (meas.valid) begin
            vfwd_r    <= meas.volt_fwd_bus;
            vrev_r    <= meas.volt_rev_bus;
            power_r   <= meas.active_power_w;
            fwd_ok_r  <= meas.fwd_bus_ok;
            rev_ok_r  <= meas.rev_bus_ok;
            term_ok_r <= meas.terminals_ok;
            state     <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!locked) begin
            step_prev <= step_pos;
          end
          ok_r   <= !locked && !term_fail && (bypass || bus_ok);
          rev_r  <= rev;
          zero_r <= !locked && !term_fail && bypass;
          move_r <= move_go;
          neg_r  <= vf_ge ^ invert;
          mag_r  <= mag;
          state  <= div_go ? S_DIV : S_APPLY;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (zero_r) begin
            step_pos <= '0;
          end else if (move_r) begin
            step_pos <= pos_clamp[STEP_BITS-1:0];
          end
          state <= S_MUL;
        end
        S_MUL: begin
          prod_r <= step_pos * $signed({1'b0, cfg.step_size});
          state  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            result.valid        <= 1'b1;
            result.success      <= ok_r;
            result.tap_changed  <= ok_r && (step_pos != step_prev);
            result.step_now     <= step_pos;
            result.step_change  <= CHANGE_BITS'(step_pos) - CHANGE_BITS'(step_prev);
            result.tap_ratio    <= ratio;
            result.flow_reverse <= ok_r && rev_r;
            state               <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (pos_ext <= POS_LIM) && (pos_ext >= -POS_LIM))
    else $error("step position beyond MAX_STEPS");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    (div_rsp.busy || div_rsp.done) |-> (state == S_DIV))
    else $error("divider active outside its state");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && div_rsp.done |=> (state == S_APPLY))
    else $error("quotient not taken");

  a_changed: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.tap_changed |-> result.success && (result.step_change != '0))
    else $error("tap change without a move");

  a_rev_ok: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.flow_reverse |-> result.success)
    else $error("reverse flow flagged on failed evaluation");
`endif

endmodule
